>>> design/cwc_pkg.sv
// Package for the cluster weighted centroid core: widths, defaults, register indexes.
// No dependencies.
package cwc_pkg;
   localparam int MaxPixelsDefault = 64;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = 40;
   localparam logic [CsrIndexWidth-1:0] CSR_MIN_PIXELS = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_PIXELS = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_VAR_FLOOR  = 2'd2;
   localparam logic [6:0]  MinPixelsReset = 7'd1;
   localparam logic [6:0]  MaxPixelsReset = 7'd64;
   localparam logic [39:0] VarFloorReset  = 40'd6400;
   localparam int DivWidth = 64;
endpackage

>>> design/cluster_weighted_centroid_core.sv
// Cluster weighted centroid core: top level with pixel store, sums and sequencer.
// Depends on cwc_pkg, cwc_divider, cwc_sqrt.
// A non-last pixel is summed, and stored if the store has room, when taken. A last
// pixel starts the end pass: two center divisions, then per axis a pass over the N
// stored pixels (one memory read, one 21x21 square and one weight multiply per
// pixel), a variance division and a square root; the divisions are skipped on zero
// charge. Input is stalled throughout, then the result waits in an output register.
// Synchronous active-high reset clears the sums and restores register defaults;
// the pixel store is not cleared.
module cluster_weighted_centroid_core #(
   parameter int MAX_PIXELS = cwc_pkg::MaxPixelsDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [19:0]                 req_pixel_x,
   input  logic signed [19:0]                 req_pixel_y,
   input  logic [15:0]                        req_pulse_height,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [19:0]                 rsp_center_x,
   output logic signed [19:0]                 rsp_center_y,
   output logic [19:0]                        rsp_sigma_x,
   output logic [19:0]                        rsp_sigma_y,
   output logic [21:0]                        rsp_charge_sum,
   output logic [6:0]                         rsp_pixel_total,
   output logic                               rsp_valid_res,
   input  logic                               csr_write,
   input  logic [cwc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [cwc_pkg::CsrDataWidth-1:0]   csr_data
);
   localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CW = $clog2(MAX_PIXELS + 1);
   localparam int DW = cwc_pkg::DivWidth;

   typedef enum logic [3:0] {
      S_LOAD, S_DIVX, S_DIVY, S_PASS, S_VDIV, S_SQRT, S_OUT
   } state_type;

   state_type state_ff;
   logic [6:0]  min_ff, max_ff;
   logic [39:0] floor_ff;

   logic signed [19:0] mem_x [MAX_PIXELS];
   logic signed [19:0] mem_y [MAX_PIXELS];
   logic [15:0]        mem_w [MAX_PIXELS];
   logic signed [19:0] rd_pos_ff;
   logic [15:0]        rd_w_ff;
   logic [15:0]        w_d_ff;      // weight aligned with sq_ff

   logic [CW-1:0]      count_ff;
   logic               ovf_ff;
   logic [21:0]        wsum_ff;
   logic signed [41:0] xsum_ff, ysum_ff;
   logic signed [36:0] xprod, yprod;

   logic               axis_ff;     // 0: x, 1: y
   logic signed [19:0] cx_ff, cy_ff;
   logic [CW-1:0]      rd_idx_ff;
   logic               rd_v_ff, mul_v_ff;
   logic [1:0]         tail_ff;
   logic [40:0]        sq_ff;       // (pos - centre)^2
   logic [63:0]        prod_ff;
   logic [63:0]        acc_ff;
   logic [19:0]        sgx_ff, sgy_ff;
   logic               sub_ff;

   // divider
   logic          div_start, div_done, sq_start, sq_done;
   logic [DW-1:0] div_a, div_q;
   logic [31:0]   root;
   logic          div_neg_ff;
   logic [63:0]   sq_in_ff;

   logic          in_acc;
   assign req_stall = (state_ff != S_LOAD) || rsp_valid;
   assign in_acc = req_valid && !req_stall;

   assign xprod = req_pixel_x * $signed({1'b0, req_pulse_height});
   assign yprod = req_pixel_y * $signed({1'b0, req_pulse_height});

   always_ff @(posedge clock) begin
      if (csr_write) begin
         unique case (csr_index)
            cwc_pkg::CSR_MIN_PIXELS: min_ff   <= csr_data[6:0];
            cwc_pkg::CSR_MAX_PIXELS: max_ff   <= csr_data[6:0];
            cwc_pkg::CSR_VAR_FLOOR:  floor_ff <= csr_data;
            default: ;
         endcase
      end
      if (reset) begin
         min_ff   <= cwc_pkg::MinPixelsReset;
         max_ff   <= cwc_pkg::MaxPixelsReset;
         floor_ff <= cwc_pkg::VarFloorReset;
      end
   end

   // store
   always_ff @(posedge clock) begin
      if (in_acc && count_ff < CW'(MAX_PIXELS)) begin
         mem_x[count_ff[AW-1:0]] <= req_pixel_x;
         mem_y[count_ff[AW-1:0]] <= req_pixel_y;
         mem_w[count_ff[AW-1:0]] <= req_pulse_height;
      end
      rd_pos_ff <= axis_ff ? mem_y[rd_idx_ff[AW-1:0]] : mem_x[rd_idx_ff[AW-1:0]];
      rd_w_ff   <= mem_w[rd_idx_ff[AW-1:0]];
   end

   // divider operand: magnitude of signed sum, or variance sum
   logic signed [41:0] num_s;
   logic [41:0]        num_mag;
   assign num_s   = axis_ff ? ysum_ff : xsum_ff;
   assign num_mag = num_s[41] ? 42'(-num_s) : 42'(num_s);
   assign div_a   = (state_ff == S_VDIV) ? acc_ff : DW'(num_mag);

   logic started_ff;
   assign div_start = !started_ff && (state_ff == S_DIVX || state_ff == S_DIVY
                      || state_ff == S_VDIV) && wsum_ff != 22'd0;
   assign sq_start  = !started_ff && state_ff == S_SQRT;

   cwc_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_a),
      .divisor(wsum_ff), .done(div_done), .quotient(div_q)
   );
   cwc_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(sq_in_ff),
      .done(sq_done), .root(root)
   );

   logic signed [19:0] cen_q;
   assign cen_q = div_neg_ff ? -div_q[19:0] : div_q[19:0];

   logic signed [20:0] diff;
   logic [20:0]        dmag;
   logic [41:0]        sq_full;
   logic [56:0]        wprod;
   logic [64:0]        acc_sum;
   assign diff    = 21'(rd_pos_ff) - 21'(axis_ff ? cy_ff : cx_ff);
   assign dmag    = diff[20] ? 21'(-diff) : 21'(diff);
   assign sq_full = dmag * dmag;
   assign wprod   = sq_ff * w_d_ff;
   assign acc_sum = {1'b0, acc_ff} + {1'b0, prod_ff};

   logic [63:0] var_q;
   assign var_q = (wsum_ff != 22'd0) ? div_q : 64'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         wsum_ff    <= '0;
         xsum_ff    <= '0;
         ysum_ff    <= '0;
         rsp_valid  <= 1'b0;
         started_ff <= 1'b0;
         axis_ff    <= 1'b0;
         rd_v_ff    <= 1'b0;
         mul_v_ff   <= 1'b0;
         sub_ff     <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
         unique case (state_ff)
            S_LOAD: begin
               if (in_acc) begin
                  if (count_ff < CW'(MAX_PIXELS)) begin
                     count_ff <= count_ff + CW'(1);
                     wsum_ff  <= wsum_ff + 22'(req_pulse_height);
                     xsum_ff  <= xsum_ff + 42'(xprod);
                     ysum_ff  <= ysum_ff + 42'(yprod);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_last) begin
                     state_ff   <= S_DIVX;
                     axis_ff    <= 1'b0;
                     started_ff <= 1'b0;
                     cx_ff      <= '0;
                     cy_ff      <= '0;
                  end
               end
            end
            S_DIVX, S_DIVY: begin
               if (!started_ff) begin
                  started_ff <= 1'b1;
                  div_neg_ff <= num_s[41];
                  if (wsum_ff == 22'd0) begin
                     started_ff <= 1'b0;
                     axis_ff    <= ~axis_ff;
                     state_ff   <= (state_ff == S_DIVX) ? S_DIVY : S_PASS;
                  end
               end else if (div_done) begin
                  started_ff <= 1'b0;
                  if (state_ff == S_DIVX) begin
                     cx_ff    <= cen_q;
                     state_ff <= S_DIVY;
                  end else begin
                     cy_ff    <= cen_q;
                     state_ff <= S_PASS;
                  end
                  axis_ff <= ~axis_ff;
               end
               if (state_ff == S_DIVY) begin
                  rd_idx_ff <= '0;
                  acc_ff    <= '0;
                  tail_ff   <= '0;
               end
            end
            S_PASS: begin
               // read -> square -> weight -> accumulate
               rd_v_ff  <= rd_idx_ff < count_ff;
               if (rd_idx_ff < count_ff) rd_idx_ff <= rd_idx_ff + CW'(1);
               sq_ff    <= sq_full[40:0];
               w_d_ff   <= rd_w_ff;
               mul_v_ff <= rd_v_ff;
               sub_ff   <= mul_v_ff;
               prod_ff  <= mul_v_ff ? 64'(wprod) : 64'd0;
               if (sub_ff) acc_ff <= acc_sum[64] ? '1 : acc_sum[63:0];
               if (rd_idx_ff >= count_ff && !rd_v_ff && !mul_v_ff && !sub_ff) begin
                  tail_ff <= tail_ff + 2'd1;
                  if (tail_ff == 2'd1) begin
                     state_ff   <= S_VDIV;
                     started_ff <= 1'b0;
                  end
               end
            end
            S_VDIV: begin
               if (!started_ff) begin
                  started_ff <= 1'b1;
                  if (wsum_ff == 22'd0) begin
                     sq_in_ff   <= 64'(floor_ff);
                     started_ff <= 1'b0;
                     state_ff   <= S_SQRT;
                  end
               end else if (div_done) begin
                  sq_in_ff   <= (var_q < 64'(floor_ff)) ? 64'(floor_ff) : var_q;
                  started_ff <= 1'b0;
                  state_ff   <= S_SQRT;
               end
            end
            S_SQRT: begin
               if (!started_ff) begin
                  started_ff <= 1'b1;
               end else if (sq_done) begin
                  started_ff <= 1'b0;
                  if (!axis_ff) begin
                     sgx_ff    <= (root > 32'hFFFFF) ? 20'hFFFFF : root[19:0];
                     axis_ff   <= 1'b1;
                     rd_idx_ff <= '0;
                     acc_ff    <= '0;
                     tail_ff   <= '0;
                     state_ff  <= S_PASS;
                  end else begin
                     sgy_ff   <= (root > 32'hFFFFF) ? 20'hFFFFF : root[19:0];
                     state_ff <= S_OUT;
                  end
               end
            end
            S_OUT: begin
               rsp_valid       <= 1'b1;
               rsp_center_x    <= cx_ff;
               rsp_center_y    <= cy_ff;
               rsp_sigma_x     <= sgx_ff;
               rsp_sigma_y     <= sgy_ff;
               rsp_charge_sum  <= wsum_ff;
               rsp_pixel_total <= 7'(count_ff);
               rsp_valid_res   <= !ovf_ff && wsum_ff != 22'd0 &&
                                  7'(count_ff) >= min_ff && 7'(count_ff) <= max_ff;
               count_ff <= '0;
               ovf_ff   <= 1'b0;
               wsum_ff  <= '0;
               xsum_ff  <= '0;
               ysum_ff  <= '0;
               axis_ff  <= 1'b0;
               state_ff <= S_LOAD;
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_LOAD |-> req_stall)
      else $error("input taken outside load");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_PIXELS))
      else $error("pixel count past store depth");
   a_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |=> rsp_valid && count_ff == '0 && wsum_ff == '0)
      else $error("cluster state not cleared with result");
endmodule

>>> design/cwc_divider.sv
// Iterative restoring divider, one quotient bit per cycle, unsigned 64 / 22.
// Depends on cwc_pkg.
module cwc_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cwc_pkg::DivWidth-1:0]  dividend,
   input  logic [21:0]                   divisor,
   output logic                          done,
   output logic [cwc_pkg::DivWidth-1:0]  quotient
);
   localparam int W = cwc_pkg::DivWidth;
   logic [W-1:0] quo_ff;
   logic [22:0]  rem_ff;
   logic [6:0]   cnt_ff;
   logic         busy_ff, done_ff;
   logic [22:0]  trial;
   logic [22:0]  diff;

   assign trial = {rem_ff[21:0], quo_ff[W-1]};
   assign diff  = trial - {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 7'(W);
            quo_ff  <= dividend;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            if (!diff[22]) begin
               rem_ff <= diff;
               quo_ff <= {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_ff <= trial;
               quo_ff <= {quo_ff[W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

>>> design/cwc_sqrt.sv
// Iterative floor square root of a 64-bit value, two radicand bits per cycle.
// Depends on cwc_pkg.
module cwc_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cwc_pkg::DivWidth-1:0]  radicand,
   output logic                          done,
   output logic [31:0]                   root
);
   logic [63:0] rad_ff;
   logic [33:0] rem_ff;
   logic [31:0] root_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [33:0] trial, test;

   assign trial = {rem_ff[31:0], rad_ff[63:62]};
   assign test  = trial - {root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd32;
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            rad_ff <= {rad_ff[61:0], 2'b00};
            if (!test[33]) begin
               rem_ff  <= test;
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               rem_ff  <= trial;
               root_ff <= {root_ff[30:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
   assign done = done_ff;
   assign root = root_ff;
endmodule

>>> bench/cluster_weighted_centroid_core_tb.sv
// Testbench for cluster_weighted_centroid_core: directed table, then random clusters
// under several register settings, checked against an in-bench centroid predictor or known table results.
// Depends on cwc_pkg and the core RTL.
`timescale 1ns / 1ps

module cluster_weighted_centroid_core_tb;

   localparam int StoreDepth = cwc_pkg::MaxPixelsDefault;
   localparam logic [cwc_pkg::CsrIndexWidth-1:0] CSR_UNUSED = 2'd3;
   localparam int DrainCycles = 700;
   localparam int WatchdogLimit = 5000;
   localparam int PhaseItems = 180;

   typedef struct packed {
      logic signed [19:0] x;
      logic signed [19:0] y;
      logic [15:0]        weight;
      logic               last;
   } pixel_type;

   typedef struct packed {
      logic signed [19:0] center_x;
      logic signed [19:0] center_y;
      logic [19:0]        sigma_x;
      logic [19:0]        sigma_y;
      logic [21:0]        charge_sum;
      logic [6:0]         pixel_total;
      logic               valid_res;
   } centroid_type;

   typedef struct packed {
      pixel_type    pix;
      logic         known;
      centroid_type known_res;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [19:0] req_pixel_x = '0;
   logic signed [19:0] req_pixel_y = '0;
   logic [15:0] req_pulse_height = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [19:0] rsp_center_x, rsp_center_y;
   logic [19:0] rsp_sigma_x, rsp_sigma_y;
   logic [21:0] rsp_charge_sum;
   logic [6:0] rsp_pixel_total;
   logic rsp_valid_res;
   logic csr_write = 1'b0;
   logic [cwc_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [cwc_pkg::CsrDataWidth-1:0] csr_data = '0;

   cluster_weighted_centroid_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pixel_x(req_pixel_x), .req_pixel_y(req_pixel_y),
      .req_pulse_height(req_pulse_height), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_center_x(rsp_center_x), .rsp_center_y(rsp_center_y),
      .rsp_sigma_x(rsp_sigma_x), .rsp_sigma_y(rsp_sigma_y),
      .rsp_charge_sum(rsp_charge_sum), .rsp_pixel_total(rsp_pixel_total),
      .rsp_valid_res(rsp_valid_res),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   logic [6:0]  cut_min = cwc_pkg::MinPixelsReset;
   logic [6:0]  cut_max = cwc_pkg::MaxPixelsReset;
   logic [39:0] var_floor = cwc_pkg::VarFloorReset;
   longint      pos_x [StoreDepth];
   longint      pos_y [StoreDepth];
   longint unsigned charge [StoreDepth];
   int          n_stored = 0;
   bit          dropped = 0;
   longint unsigned charge_total = 0;
   longint      moment_x = 0;
   longint      moment_y = 0;

   centroid_type   pending_centroids[$];
   int             errors = 0;
   bit             quiet = 0;
   int             idle_cycles = 0;
   table_row_type  rows[$];

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [19:0] rms_spread(bit use_y, longint centre);
      longint unsigned acc, sq, term, v, s;
      longint d;
      acc = 0;
      for (int i = 0; i < n_stored; i++) begin
         d = (use_y ? pos_y[i] : pos_x[i]) - centre;
         sq = d * d;
         term = sq * charge[i];
         acc = (acc + term < acc) ? 64'hFFFF_FFFF_FFFF_FFFF : acc + term;
      end
      v = (charge_total != 0) ? acc / charge_total : 0;
      if (v < var_floor) v = var_floor;
      s = floor_sqrt(v);
      return (s > 64'hFFFFF) ? 20'hFFFFF : s[19:0];
   endfunction

   // Updates the cluster state with one pixel; returns 1 with a centroid on last.
   function automatic bit accumulate_pixel(pixel_type p, output centroid_type c);
      longint cx, cy;
      if (n_stored < StoreDepth) begin
         pos_x[n_stored] = p.x;
         pos_y[n_stored] = p.y;
         charge[n_stored] = p.weight;
         n_stored++;
         charge_total += p.weight;
         moment_x += longint'(p.x) * longint'(p.weight);
         moment_y += longint'(p.y) * longint'(p.weight);
      end else begin
         dropped = 1;
      end
      c = '0;
      if (!p.last) return 0;
      cx = 0;
      cy = 0;
      if (charge_total != 0) begin
         cx = moment_x / longint'(charge_total);
         cy = moment_y / longint'(charge_total);
      end
      c.center_x = cx[19:0];
      c.center_y = cy[19:0];
      c.sigma_x = rms_spread(0, cx);
      c.sigma_y = rms_spread(1, cy);
      c.charge_sum = charge_total[21:0];
      c.pixel_total = n_stored[6:0];
      c.valid_res = !dropped && charge_total != 0 &&
                    n_stored >= cut_min && n_stored <= cut_max;
      n_stored = 0;
      dropped = 0;
      charge_total = 0;
      moment_x = 0;
      moment_y = 0;
      return 1;
   endfunction

   task automatic send_pixel(pixel_type p, bit known, centroid_type known_res);
      centroid_type c;
      if (!quiet && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_x <= p.x;
      req_pixel_y <= p.y;
      req_pulse_height <= p.weight;
      req_last <= p.last;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      if (accumulate_pixel(p, c)) pending_centroids.push_back(known ? known_res : c);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_centroids.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(logic [cwc_pkg::CsrIndexWidth-1:0] idx,
                            logic [cwc_pkg::CsrDataWidth-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      case (idx)
         cwc_pkg::CSR_MIN_PIXELS: cut_min = val[6:0];
         cwc_pkg::CSR_MAX_PIXELS: cut_max = val[6:0];
         cwc_pkg::CSR_VAR_FLOOR:  var_floor = val[39:0];
         default: ;
      endcase
   endtask

   // upper bits of the narrow registers carry noise; they must be masked
   task automatic set_cuts(logic [6:0] lo, logic [6:0] hi, logic [39:0] fl);
      write_reg(cwc_pkg::CSR_MIN_PIXELS, 40'({$urandom(), $urandom()}) & ~40'h7F | 40'(lo));
      write_reg(cwc_pkg::CSR_MAX_PIXELS, 40'({$urandom(), $urandom()}) & ~40'h7F | 40'(hi));
      write_reg(cwc_pkg::CSR_VAR_FLOOR, fl);
      write_reg(CSR_UNUSED, 40'({$urandom(), $urandom()}));
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_row(int x, int y, int w, bit last, bit known, centroid_type r);
      table_row_type t;
      t.pix = '{x: 20'(x), y: 20'(y), weight: 16'(w), last: last};
      t.known = known;
      t.known_res = r;
      rows.push_back(t);
   endtask

   task automatic random_cluster(output int len);
      pixel_type p;
      logic signed [19:0] bx, by;
      int r, spread_w, mode;
      r = $urandom_range(99);
      len = (r < 80) ? $urandom_range(8, 1) : (r < 95) ? $urandom_range(40, 9)
                                                      : $urandom_range(70, 60);
      bx = 20'($urandom());
      by = 20'($urandom());
      spread_w = 1 << $urandom_range(12, 2);
      mode = $urandom_range(9);
      for (int i = 0; i < len; i++) begin
         if (mode == 0) begin
            p.x = 20'($urandom());
            p.y = 20'($urandom());
         end else begin
            p.x = 20'(bx + $signed($urandom_range(2 * spread_w)) - spread_w);
            p.y = 20'(by + $signed($urandom_range(2 * spread_w)) - spread_w);
         end
         r = $urandom_range(9);
         p.weight = (r == 0) ? 16'd0 : (r < 4) ? 16'($urandom_range(255)) : 16'($urandom());
         p.last = (i == len - 1);
         send_pixel(p, 0, '0);
      end
   endtask

   // result side: random stall, compare against oldest expectation
   always @(posedge clock) begin
      centroid_type e;
      rsp_stall <= !quiet && $urandom_range(99) < 12;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_centroids.size() == 0) begin
            $error("unexpected result item");
            errors++;
         end else begin
            e = pending_centroids.pop_front();
            if (rsp_center_x !== e.center_x) begin
               $error("center_x exp %0d got %0d", e.center_x, rsp_center_x); errors++;
            end
            if (rsp_center_y !== e.center_y) begin
               $error("center_y exp %0d got %0d", e.center_y, rsp_center_y); errors++;
            end
            if (rsp_sigma_x !== e.sigma_x) begin
               $error("sigma_x exp %0d got %0d", e.sigma_x, rsp_sigma_x); errors++;
            end
            if (rsp_sigma_y !== e.sigma_y) begin
               $error("sigma_y exp %0d got %0d", e.sigma_y, rsp_sigma_y); errors++;
            end
            if (rsp_charge_sum !== e.charge_sum) begin
               $error("charge_sum exp %0d got %0d", e.charge_sum, rsp_charge_sum); errors++;
            end
            if (rsp_pixel_total !== e.pixel_total) begin
               $error("pixel_total exp %0d got %0d", e.pixel_total, rsp_pixel_total); errors++;
            end
            if (rsp_valid_res !== e.valid_res) begin
               $error("valid_res exp %0d got %0d", e.valid_res, rsp_valid_res); errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      int sent, len;
      centroid_type none;
      none = '0;
      // known rows: single-pixel clusters (variance 0) or zero charge, so sigma is sqrt(6400)
      add_row(0, 0, 0, 1, 1, '{0, 0, 80, 80, 0, 1, 0});
      add_row(524287, -524288, 65535, 1, 1, '{524287, -524288, 80, 80, 65535, 1, 1});
      add_row(-524288, 524287, 1, 1, 1, '{-524288, 524287, 80, 80, 1, 1, 1});
      add_row(5, 5, 0, 0, 0, none);
      add_row(7, -7, 0, 1, 1, '{0, 0, 80, 80, 0, 2, 0});
      add_row(100, 200, 3, 0, 0, none);
      add_row(-100, -50, 65535, 1, 0, none);
      add_row(524287, 524287, 65535, 0, 0, none);
      add_row(-524288, -524288, 65535, 1, 0, none);
      add_row(1000, -3000, 40000, 0, 0, none);
      add_row(1300, -2600, 12000, 0, 0, none);
      add_row(700, -3500, 65535, 0, 0, none);
      add_row(2000, -3100, 1, 0, 0, none);
      add_row(-20000, 90000, 30000, 1, 0, none);
      add_row(-7, 3, 9, 0, 0, none);
      add_row(-8, 4, 10, 1, 0, none);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) send_pixel(rows[i].pix, rows[i].known, rows[i].known_res);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: set_cuts(cwc_pkg::MinPixelsReset, cwc_pkg::MaxPixelsReset,
                        cwc_pkg::VarFloorReset);
            1: set_cuts(7'd0, 7'd0, 40'd0);
            2: set_cuts(7'd64, 7'd64, 40'hFF_FFFF_FFFF);
            3: set_cuts(7'd2, 7'd20, 40'd1);
            default: set_cuts(7'($urandom_range(8)), 7'($urandom_range(64, 4)),
                              40'($urandom_range(99999)));
         endcase
         quiet = (ph == 2);
         sent = 0;
         while (sent < PhaseItems) begin
            random_cluster(len);
            sent += len;
         end
         quiet = 0;
         drain();
      end

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
